>>> rtl/cbt_pkg.sv
`timescale 1ns / 1ps
// cbt_pkg: widths, limits, sequencer states and the segment split function
// for the CAN bit timing solver. No dependencies.
package cbt_pkg;

  localparam int CLK_W   = 32;
  localparam int RATE_W  = 20;
  localparam int DIV_W   = 32;
  localparam int CNT_W   = 5;
  localparam int T_W     = 5;
  localparam int PRESC_W = 9;

  localparam logic [T_W-1:0] MIN_QUANTA        = 5'd8;
  localparam logic [T_W-1:0] MAX_QUANTA        = 5'd25;
  localparam logic [T_W-1:0] MAX_PROP_QUANTA   = 5'd8;
  localparam logic [T_W-1:0] MIN_PHASE2_QUANTA = 5'd2;
  localparam logic [T_W-1:0] MAX_JUMP_QUANTA   = 5'd4;
  localparam logic [DIV_W-1:0] PRESC_LIMIT     = 32'd256;
  localparam logic [CNT_W-1:0] DIV_LAST        = 5'(DIV_W - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_RATIO,
    S_RATIO,
    S_TRY,
    S_DIV_PRESC,
    S_PRESC,
    S_DIV_CLK,
    S_CLK,
    S_DIV_ACT,
    S_CMP,
    S_NEXT,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] presc_m1;
    logic [1:0] sjw_m1;
    logic [2:0] ph1_m1;
    logic [2:0] ph2_m1;
    logic [2:0] prop_m1;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] sjw_m1;
    logic [2:0] ph1_m1;
    logic [2:0] ph2_m1;
    logic [2:0] prop_m1;
  } seg_t;

  // split t quanta into sync, propagation, phase 1 and phase 2, and pick the jump width
  function automatic seg_t seg_calc(input logic [T_W-1:0] t);
    logic signed [6:0] half;
    logic signed [6:0] ph1;
    logic signed [6:0] ph2;
    logic signed [6:0] prop;
    logic signed [6:0] sjw;
    seg_t s;
    half = (t > MAX_PROP_QUANTA) ? 7'(t - MAX_PROP_QUANTA) : 7'sd0;
    ph2  = half >>> 1;
    if (ph2 < $signed(7'(MIN_PHASE2_QUANTA))) ph2 = 7'(MIN_PHASE2_QUANTA);
    ph1  = (t == MIN_QUANTA) ? 7'sd1 : ph2;
    prop = $signed(7'(t)) - ph1 - ph2 - 7'sd1;
    sjw  = (ph1 < $signed(7'(MAX_JUMP_QUANTA))) ? ph1 : 7'(MAX_JUMP_QUANTA);
    s.ok = (ph1 >= 7'sd1) && (ph1 <= 7'sd8) && (ph2 >= 7'sd1) && (ph2 <= 7'sd8) &&
           (prop >= 7'sd1) && (prop <= 7'sd8) && (sjw >= 7'sd1) && (sjw <= 7'sd4);
    s.sjw_m1  = 2'(sjw - 7'sd1);
    s.ph1_m1  = 3'(ph1 - 7'sd1);
    s.ph2_m1  = 3'(ph2 - 7'sd1);
    s.prop_m1 = 3'(prop - 7'sd1);
    return s;
  endfunction

endpackage

>>> rtl/cbt_in_if.sv
`timescale 1ns / 1ps
// cbt_in_if: input channel, clock frequency and wanted bit rate per word.
// Depends on cbt_pkg.
interface cbt_in_if import cbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CLK_W-1:0]  clock_hz;
  logic [RATE_W-1:0] wanted_bitrate;

  modport source (output valid, output clock_hz, output wanted_bitrate, input ready);
  modport sink   (input valid, input clock_hz, input wanted_bitrate, output ready);
endinterface

>>> rtl/cbt_out_if.sv
`timescale 1ns / 1ps
// cbt_out_if: result channel, one timing word per input word.
// Depends on nothing.
interface cbt_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [7:0] prescaler_minus_one;
  logic [1:0] jump_width_minus_one;
  logic [2:0] phase1_minus_one;
  logic [2:0] phase2_minus_one;
  logic [2:0] propagation_minus_one;

  modport source (output valid, output ok, output prescaler_minus_one,
                  output jump_width_minus_one, output phase1_minus_one,
                  output phase2_minus_one, output propagation_minus_one, input ready);
  modport sink   (input valid, input ok, input prescaler_minus_one,
                  input jump_width_minus_one, input phase1_minus_one,
                  input phase2_minus_one, input propagation_minus_one, output ready);
endinterface

>>> rtl/can_bit_timing_solver.sv
`timescale 1ns / 1ps
// Computes the CAN bit timing for a given peripheral clock and bit rate.
// One shared restoring divider first runs the clock/rate ratio, then tries
// each quanta count from 25 down to 8. A count whose prescaler is zero, above
// 256 or an exact divisor needs only the prescaler division; a count whose
// achieved rate is compared also divides the clock by the prescaler and that
// quotient by the count. The search stops early on an exact divisor. The
// result register loads via S_DONE with no division for a zero bit rate,
// after the ratio division when the ratio is too small, and after the search
// otherwise. in_ch.ready is high only while the solver is idle. A finished
// result waits in the output register, so the next word can be taken while the last result is still unread.
// Depends on cbt_pkg, cbt_in_if, cbt_out_if.
module can_bit_timing_solver import cbt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  cbt_in_if.sink    in_ch,
  cbt_out_if.source out_ch
);

  state_t state_r, state_nxt;

  logic [CLK_W-1:0]   clk_hz_r, clk_hz_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;
  logic [DIV_W-1:0]   ratio_r, ratio_nxt;
  logic [T_W-1:0]     t_r, t_nxt;
  logic [PRESC_W-1:0] presc_r, presc_nxt;
  logic [T_W-1:0]     best_t_r, best_t_nxt;
  logic [PRESC_W-1:0] best_presc_r, best_presc_nxt;
  logic [RATE_W-1:0]  best_diff_r, best_diff_nxt;

  // shared divider
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] step_rem, step_quo;

  res_t pend_r, pend_nxt;
  res_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [DIV_W-1:0] diff;
  seg_t seg;

  assign trial = {rem_r, quo_r[DIV_W-1]} - {1'b0, dvs_r};

  always_comb begin
    if (!trial[DIV_W]) begin
      step_rem = trial[DIV_W-1:0];
      step_quo = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      step_rem = {rem_r[DIV_W-2:0], quo_r[DIV_W-1]};
      step_quo = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  assign diff = (quo_r > DIV_W'(rate_r)) ? quo_r - DIV_W'(rate_r) : DIV_W'(rate_r) - quo_r;
  assign seg  = seg_calc(best_t_r);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    clk_hz_nxt     = clk_hz_r;
    rate_nxt       = rate_r;
    ratio_nxt      = ratio_r;
    t_nxt          = t_r;
    presc_nxt      = presc_r;
    best_t_nxt     = best_t_r;
    best_presc_nxt = best_presc_r;
    best_diff_nxt  = best_diff_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dvs_nxt        = dvs_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          clk_hz_nxt = in_ch.clock_hz;
          rate_nxt   = in_ch.wanted_bitrate;
          if (in_ch.wanted_bitrate == '0) begin
            pend_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            rem_nxt   = '0;
            quo_nxt   = in_ch.clock_hz;
            dvs_nxt   = DIV_W'(in_ch.wanted_bitrate);
            cnt_nxt   = '0;
            state_nxt = S_DIV_RATIO;
          end
        end
      end
      S_DIV_RATIO, S_DIV_PRESC, S_DIV_CLK, S_DIV_ACT: begin
        rem_nxt = step_rem;
        quo_nxt = step_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          unique case (state_r)
            S_DIV_RATIO: state_nxt = S_RATIO;
            S_DIV_PRESC: state_nxt = S_PRESC;
            S_DIV_CLK:   state_nxt = S_CLK;
            default:     state_nxt = S_CMP;
          endcase
        end
      end
      S_RATIO: begin
        ratio_nxt = quo_r;
        if (quo_r < DIV_W'(MIN_QUANTA - 1'b1)) begin
          pend_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          t_nxt         = MAX_QUANTA;
          best_t_nxt    = '0;
          best_diff_nxt = rate_r;
          state_nxt     = S_TRY;
        end
      end
      S_TRY: begin
        rem_nxt   = '0;
        quo_nxt   = ratio_r;
        dvs_nxt   = DIV_W'(t_r);
        cnt_nxt   = '0;
        state_nxt = S_DIV_PRESC;
      end
      S_PRESC: begin
        if (quo_r == '0 || quo_r > PRESC_LIMIT) begin
          state_nxt = S_NEXT;
        end else if (rem_r == '0) begin
          best_t_nxt     = t_r;
          best_presc_nxt = quo_r[PRESC_W-1:0];
          state_nxt      = S_FIN;
        end else begin
          presc_nxt = quo_r[PRESC_W-1:0];
          rem_nxt   = '0;
          quo_nxt   = clk_hz_r;
          dvs_nxt   = quo_r;
          cnt_nxt   = '0;
          state_nxt = S_DIV_CLK;
        end
      end
      S_CLK: begin
        rem_nxt   = '0;
        dvs_nxt   = DIV_W'(t_r);
        cnt_nxt   = '0;
        state_nxt = S_DIV_ACT;
      end
      S_CMP: begin
        if (diff < DIV_W'(best_diff_r)) begin
          best_diff_nxt  = diff[RATE_W-1:0];
          best_t_nxt     = t_r;
          best_presc_nxt = presc_r;
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (t_r == MIN_QUANTA) begin
          state_nxt = S_FIN;
        end else begin
          t_nxt     = t_r - 1'b1;
          state_nxt = S_TRY;
        end
      end
      S_FIN: begin
        if (best_t_r == '0 || !seg.ok) begin
          pend_nxt = '0;
        end else begin
          pend_nxt.ok       = 1'b1;
          pend_nxt.presc_m1 = 8'(best_presc_r - 1'b1);
          pend_nxt.sjw_m1   = seg.sjw_m1;
          pend_nxt.ph1_m1   = seg.ph1_m1;
          pend_nxt.ph2_m1   = seg.ph2_m1;
          pend_nxt.prop_m1  = seg.prop_m1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clk_hz_r     <= clk_hz_nxt;
    rate_r       <= rate_nxt;
    ratio_r      <= ratio_nxt;
    t_r          <= t_nxt;
    presc_r      <= presc_nxt;
    best_t_r     <= best_t_nxt;
    best_presc_r <= best_presc_nxt;
    best_diff_r  <= best_diff_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dvs_r        <= dvs_nxt;
    cnt_r        <= cnt_nxt;
    pend_r       <= pend_nxt;
    out_r        <= out_nxt;
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.ok                    = out_r.ok;
  assign out_ch.prescaler_minus_one   = out_r.presc_m1;
  assign out_ch.jump_width_minus_one  = out_r.sjw_m1;
  assign out_ch.phase1_minus_one      = out_r.ph1_m1;
  assign out_ch.phase2_minus_one      = out_r.ph2_m1;
  assign out_ch.propagation_minus_one = out_r.prop_m1;

  // divider never runs on a zero divisor
  a_dvs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_RATIO || state_r == S_DIV_PRESC ||
     state_r == S_DIV_CLK || state_r == S_DIV_ACT) |-> (dvs_r != '0))
    else $error("divide by zero");

  // remainder stays below divisor at the end of a division
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRESC || state_r == S_CMP) |-> (rem_r < dvs_r))
    else $error("remainder out of range");

  // best distance never grows past the wanted rate
  a_best_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP || state_r == S_NEXT) |-> (best_diff_r <= rate_r))
    else $error("best distance above rate");

  // a chosen count lies in the searched range
  a_best_t: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && best_t_r != '0) |->
      (best_t_r >= MIN_QUANTA && best_t_r <= MAX_QUANTA && best_presc_r != '0))
    else $error("chosen count out of range");

  // a result is only offered from the done state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result loaded outside done");

endmodule
